// ===== rtl/wall_distance_nearest_face_defines.svh =====
// ----------------------------------------------------------------------------
// wall distance assertion macros
// shared concurrent assertion forms for the wall distance block
// ----------------------------------------------------------------------------
`ifndef WALL_DISTANCE_NEAREST_FACE_DEFINES_SVH
`define WALL_DISTANCE_NEAREST_FACE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define WDF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define WDF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/wdf_pkg.sv =====
// ----------------------------------------------------------------------------
// wdf_pkg
// opcodes, widths and the request kind enum shared by the wall distance block
// ----------------------------------------------------------------------------
package wdf_pkg;

	localparam int OP_W    = 3;
	localparam int IDX_W   = 12;
	localparam int NORM_W  = 16;
	localparam int DIST_W  = 25;
	localparam int FIDX_W  = 10;
	localparam int CNT_W   = 11;

	localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
	localparam logic [OP_W-1:0] OP_QUERY = 3'd1;
	localparam logic [OP_W-1:0] OP_STATE = 3'd2;
	localparam logic [OP_W-1:0] OP_WALL  = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

	localparam logic CFG_FACE_COUNT = 1'b0;
	localparam logic CFG_THREE_D    = 1'b1;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	typedef enum logic [2:0] {
		K_NONE,
		K_LOAD,
		K_QUERY,
		K_STATE,
		K_WALL,
		K_CLEAR
	} kind_t;

endpackage

// ===== rtl/wdf_front.sv =====
// ----------------------------------------------------------------------------
// wdf_front
// accepts requests, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module wdf_front #(
	parameter int QW = 120,
	parameter int DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [wdf_pkg::OP_W-1:0] op,
	input  logic [QW-4:0]         payload,
	output logic                  q_valid,
	input  logic                  q_ready,
	output wdf_pkg::kind_t        q_kind,
	output logic [QW-4:0]         q_payload
);
	import wdf_pkg::*;

	localparam int AW = $clog2(DEPTH);

	kind_t           kind_c;
	logic [QW-4:0]   pay_q [DEPTH];
	kind_t           kind_q [DEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;
	logic            push, pop;

	always_comb begin
		case (op)
			OP_LOAD:  kind_c = K_LOAD;
			OP_QUERY: kind_c = K_QUERY;
			OP_STATE: kind_c = K_STATE;
			OP_WALL:  kind_c = K_WALL;
			OP_CLEAR: kind_c = K_CLEAR;
			default:  kind_c = K_NONE;
		endcase
	end

	assign in_ready  = (cnt_q != (AW+1)'(DEPTH));
	assign push      = in_valid && in_ready;
	assign q_valid   = (cnt_q != '0);
	assign pop       = q_valid && q_ready;
	assign q_kind    = kind_q[rp_q];
	assign q_payload = pay_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			pay_q[wp_q]  <= payload;
			kind_q[wp_q] <= kind_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

// ===== rtl/wdf_back.sv =====
// ----------------------------------------------------------------------------
// wdf_back
// face table, state store and the scan / projection sequencer
// ----------------------------------------------------------------------------
`include "wall_distance_nearest_face_defines.svh"

module wdf_back #(
	parameter int MAX_WALL_FACES = 1024,
	parameter int MAX_STATES = 4096,
	parameter int COORD_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	output logic                        q_ready,
	input  wdf_pkg::kind_t              q_kind,
	input  logic [wdf_pkg::IDX_W-1:0]   q_index,
	input  logic signed [COORD_BITS-1:0] q_px,
	input  logic signed [COORD_BITS-1:0] q_py,
	input  logic signed [COORD_BITS-1:0] q_pz,
	input  logic signed [wdf_pkg::NORM_W-1:0] q_nx,
	input  logic signed [wdf_pkg::NORM_W-1:0] q_ny,
	input  logic signed [wdf_pkg::NORM_W-1:0] q_nz,
	input  logic [wdf_pkg::CNT_W-1:0]   face_count,
	input  logic                        three_d,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [wdf_pkg::FIDX_W-1:0]  face_index,
	output logic [wdf_pkg::DIST_W-1:0]  distance,
	output logic                        valid_res
);
	import wdf_pkg::*;

	localparam int FA = (MAX_WALL_FACES > 1) ? $clog2(MAX_WALL_FACES) : 1;
	localparam int SA = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam int FN = $clog2(MAX_WALL_FACES + 1);
	localparam int DW = COORD_BITS + 1;
	localparam int SQW = 2 * DW + 2;
	localparam int PW = DW + NORM_W + 2;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_SCAN_END, S_PRJ_RD, S_PRJ_MUL, S_PRJ_SUM,
		S_ST_RD, S_ST_WR, S_CLR, S_OUT
	} st_t;

	st_t st_q;

	logic signed [COORD_BITS-1:0] cx_m [MAX_WALL_FACES];
	logic signed [COORD_BITS-1:0] cy_m [MAX_WALL_FACES];
	logic signed [COORD_BITS-1:0] cz_m [MAX_WALL_FACES];
	logic signed [NORM_W-1:0]     nx_m [MAX_WALL_FACES];
	logic signed [NORM_W-1:0]     ny_m [MAX_WALL_FACES];
	logic signed [NORM_W-1:0]     nz_m [MAX_WALL_FACES];
	logic [DIST_W-1:0]            sd_m [MAX_STATES];

	logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
	logic [IDX_W-1:0]             idx_q;
	kind_t                        kind_q;
	logic [FN-1:0]                n_q;
	logic                         td_q;
	logic [FN-1:0]                scan_q;
	logic                         rd_v_s1, rd_v_s2;
	logic [FA-1:0]                rd_f_s1, rd_f_s2;
	logic signed [COORD_BITS-1:0] rx_s1, ry_s1, rz_s1;
	logic signed [NORM_W-1:0]     rnx_s1, rny_s1, rnz_s1;
	logic [SQW-1:0]               sq_s2;
	logic                         have_q;
	logic [SQW-1:0]               best_d_q;
	logic [FA-1:0]                best_q;
	logic [FIDX_W-1:0]            last_q;
	logic signed [PW-1:0]         mx_q, my_q, mz_q;
	logic [DIST_W-1:0]            dist_q;
	logic [DIST_W-1:0]            sd_rd_q;
	logic [SA-1:0]                clr_q;
	logic [FIDX_W-1:0]            o_face_q;
	logic [DIST_W-1:0]            o_dist_q;
	logic                         o_vr_q;
	logic                         out_v_q;

	logic [FA-1:0]                rd_addr;
	logic                         rd_en;
	logic signed [DW-1:0]         dx_c, dy_c, dz_c;
	logic signed [PW+1:0]         psum_c;
	logic [PW+1:0]                pabs_c;
	logic [PW+1:0]                psh_c;
	logic [DIST_W-1:0]            dsat_c;
	logic [DIST_W-1:0]            vmin_c;
	logic                         st_ok;

	assign q_ready    = (st_q == S_IDLE) && !out_v_q;
	assign out_valid  = out_v_q;
	assign face_index = o_face_q;
	assign distance   = o_dist_q;
	assign valid_res  = o_vr_q;
	assign st_ok      = ({{(32-IDX_W){1'b0}}, idx_q} < 32'(MAX_STATES));

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = best_q;
		if (st_q == S_SCAN && scan_q < n_q) begin
			rd_en   = 1'b1;
			rd_addr = scan_q[FA-1:0];
		end else if (st_q == S_PRJ_RD) begin
			rd_en   = 1'b1;
			rd_addr = best_q;
		end
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (q_valid && q_ready && q_kind == K_LOAD &&
				{{(32-IDX_W){1'b0}}, q_index} < 32'(MAX_WALL_FACES)) begin
			cx_m[q_index[FA-1:0]] <= q_px;
			cy_m[q_index[FA-1:0]] <= q_py;
			cz_m[q_index[FA-1:0]] <= q_pz;
			nx_m[q_index[FA-1:0]] <= q_nx;
			ny_m[q_index[FA-1:0]] <= q_ny;
			nz_m[q_index[FA-1:0]] <= q_nz;
		end
		if (rd_en) begin
			rx_s1  <= cx_m[rd_addr];
			ry_s1  <= cy_m[rd_addr];
			rz_s1  <= cz_m[rd_addr];
			rnx_s1 <= nx_m[rd_addr];
			rny_s1 <= ny_m[rd_addr];
			rnz_s1 <= nz_m[rd_addr];
		end
		sd_rd_q <= sd_m[idx_q[SA-1:0]];
		if (st_q == S_ST_WR && st_ok)
			sd_m[idx_q[SA-1:0]] <= vmin_c;
		else if (q_valid && q_ready && q_kind == K_WALL &&
				{{(32-IDX_W){1'b0}}, q_index} < 32'(MAX_STATES))
			sd_m[q_index[SA-1:0]] <= '0;
		else if (st_q == S_CLR)
			sd_m[clr_q] <= DIST_MAX;
	end

	assign dx_c = DW'(px_q) - DW'(rx_s1);
	assign dy_c = DW'(py_q) - DW'(ry_s1);
	assign dz_c = td_q ? (DW'(pz_q) - DW'(rz_s1)) : '0;

	assign psum_c = (PW+2)'(mx_q) + (PW+2)'(my_q) + (PW+2)'(mz_q);
	assign pabs_c = psum_c[PW+1] ? (PW+2)'(-psum_c) : (PW+2)'(psum_c);
	assign psh_c  = pabs_c >> 14;
	assign dsat_c = (psh_c > (PW+2)'(DIST_MAX)) ? DIST_MAX : psh_c[DIST_W-1:0];
	assign vmin_c = (n_q == '0) ? '0 : ((dist_q < sd_rd_q) ? dist_q : sd_rd_q);

	always_ff @(posedge clk) begin
		// squared distance pipeline, one face per cycle
		sq_s2   <= SQW'(dx_c * dx_c) + SQW'(dy_c * dy_c) + SQW'(dz_c * dz_c);
		rd_f_s2 <= rd_f_s1;
		if (st_q == S_PRJ_MUL) begin
			mx_q <= PW'(dx_c * rnx_s1);
			my_q <= PW'(dy_c * rny_s1);
			mz_q <= PW'(dz_c * rnz_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_CLR;
			clr_q    <= '0;
			scan_q   <= '0;
			rd_v_s1  <= 1'b0;
			rd_v_s2  <= 1'b0;
			rd_f_s1  <= '0;
			have_q   <= 1'b0;
			best_q   <= '0;
			best_d_q <= '0;
			last_q   <= '0;
			out_v_q  <= 1'b0;
			o_face_q <= '0;
			o_dist_q <= '0;
			o_vr_q   <= 1'b0;
			kind_q   <= K_NONE;
			idx_q    <= '0;
			n_q      <= '0;
			td_q     <= 1'b1;
			px_q     <= '0;
			py_q     <= '0;
			pz_q     <= '0;
			dist_q   <= '0;
		end else begin
			if (st_q == S_OUT) out_v_q <= 1'b1;
			else if (out_v_q && out_ready) out_v_q <= 1'b0;
			rd_v_s1 <= rd_en && st_q == S_SCAN;
			rd_f_s1 <= rd_addr;
			rd_v_s2 <= rd_v_s1;
			if (rd_v_s2 && (!have_q || sq_s2 < best_d_q)) begin
				have_q   <= 1'b1;
				best_d_q <= sq_s2;
				best_q   <= rd_f_s2;
			end
			case (st_q)
				S_IDLE: begin
					if (q_valid && q_ready) begin
						kind_q <= q_kind;
						idx_q  <= q_index;
						px_q   <= q_px;
						py_q   <= q_py;
						pz_q   <= q_pz;
						td_q   <= three_d;
						n_q    <= (32'(face_count) > 32'(MAX_WALL_FACES)) ?
							FN'(MAX_WALL_FACES) : FN'(face_count);
						scan_q <= '0;
						have_q <= 1'b0;
						best_q <= (q_kind == K_STATE) ? last_q[FA-1:0] : '0;
						o_face_q <= '0;
						o_dist_q <= '0;
						o_vr_q   <= 1'b0;
						case (q_kind)
							K_QUERY: st_q <= S_SCAN;
							K_STATE: st_q <= S_PRJ_RD;
							K_CLEAR: begin
								clr_q <= '0;
								st_q  <= S_CLR;
							end
							default: st_q <= S_OUT;
						endcase
					end
				end
				S_SCAN: begin
					if (scan_q < n_q) scan_q <= scan_q + 1'b1;
					else st_q <= S_SCAN_END;
				end
				S_SCAN_END: begin
					if (!rd_v_s1 && !rd_v_s2) st_q <= S_PRJ_RD;
				end
				S_PRJ_RD:  st_q <= S_PRJ_MUL;
				S_PRJ_MUL: st_q <= S_PRJ_SUM;
				S_PRJ_SUM: begin
					dist_q <= (n_q == '0) ? '0 : dsat_c;
					if (kind_q == K_QUERY) begin
						last_q   <= FIDX_W'(best_q);
						o_face_q <= FIDX_W'(best_q);
						o_dist_q <= (n_q == '0) ? '0 : dsat_c;
						o_vr_q   <= 1'b1;
						st_q     <= S_OUT;
					end else begin
						st_q <= S_ST_RD;
					end
				end
				S_ST_RD: st_q <= S_ST_WR;
				S_ST_WR: begin
					if (st_ok) begin
						o_face_q <= (n_q == '0) ? '0 : last_q;
						o_dist_q <= vmin_c;
						o_vr_q   <= 1'b1;
					end
					st_q <= S_OUT;
				end
				S_OUT: st_q <= S_IDLE;
				S_CLR: begin
					if (clr_q == SA'(MAX_STATES-1))
						st_q <= (kind_q == K_CLEAR) ? S_OUT : S_IDLE;
					else clr_q <= clr_q + 1'b1;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`WDF_ASSERT_IMP(a_out_zero, out_valid && !valid_res, face_index == '0 && distance == '0)
	`WDF_ASSERT_NEXT(a_scan_bound, st_q == S_SCAN, scan_q <= n_q)
	`WDF_ASSERT_IMP(a_ready_idle, q_ready, st_q == S_IDLE)
	`WDF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(distance))

endmodule

// ===== rtl/wall_distance_nearest_face.sv =====
// ----------------------------------------------------------------------------
// wall_distance_nearest_face
// nearest wall face search and projected wall distance per state
// ----------------------------------------------------------------------------
// cell query scans faces below the face count one face per cycle through the face table
// read port, then projects onto the nearest; state point projects onto the last query's face
// throughput: one request at a time in the back end, which waits until its result is taken
// clear states sweeps the state memory one entry per cycle
// reset: same clearing sweep after reset, requests wait until it finishes
module wall_distance_nearest_face #(
	parameter int MAX_WALL_FACES = 1024,
	parameter int MAX_STATES = 4096,
	parameter int COORD_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [wdf_pkg::OP_W-1:0]    op,
	input  logic [wdf_pkg::IDX_W-1:0]   index,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] pos_z,
	input  logic signed [wdf_pkg::NORM_W-1:0] norm_x,
	input  logic signed [wdf_pkg::NORM_W-1:0] norm_y,
	input  logic signed [wdf_pkg::NORM_W-1:0] norm_z,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [wdf_pkg::CNT_W-1:0]   cfg_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [wdf_pkg::FIDX_W-1:0]  face_index,
	output logic [wdf_pkg::DIST_W-1:0]  distance,
	output logic                        valid_res
);
	import wdf_pkg::*;

	localparam int PL = IDX_W + 3*COORD_BITS + 3*NORM_W;
	localparam int QW = PL + 3;

	logic [CNT_W-1:0] count_q;
	logic             td_q;
	logic             qv, qr;
	kind_t            qk;
	logic [PL-1:0]    qp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			td_q    <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FACE_COUNT: count_q <= cfg_data;
				CFG_THREE_D:    td_q <= cfg_data[0];
				default:        td_q <= td_q;
			endcase
		end
	end

	wdf_front #(.QW(QW), .DEPTH(2)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op),
		.payload({index, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z}),
		.q_valid(qv), .q_ready(qr), .q_kind(qk), .q_payload(qp)
	);

	wdf_back #(
		.MAX_WALL_FACES(MAX_WALL_FACES), .MAX_STATES(MAX_STATES),
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(qv), .q_ready(qr), .q_kind(qk),
		.q_index(qp[PL-1 -: IDX_W]),
		.q_px(qp[3*NORM_W+3*COORD_BITS-1 -: COORD_BITS]),
		.q_py(qp[3*NORM_W+2*COORD_BITS-1 -: COORD_BITS]),
		.q_pz(qp[3*NORM_W+COORD_BITS-1 -: COORD_BITS]),
		.q_nx(qp[3*NORM_W-1 -: NORM_W]),
		.q_ny(qp[2*NORM_W-1 -: NORM_W]),
		.q_nz(qp[NORM_W-1:0]),
		.face_count(count_q), .three_d(td_q),
		.out_valid(out_valid), .out_ready(out_ready),
		.face_index(face_index), .distance(distance), .valid_res(valid_res)
	);

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// wall distance nearest face testbench
// drives face loads, cell queries and state operations through the request
// channel, writes the face count and dimension registers between phases and
// checks each result against an in-bench nearest face and distance predictor
// ----------------------------------------------------------------------------
module tb;
	import wdf_pkg::*;

	localparam int FACES = 1024;
	localparam int STATES = 4096;
	localparam int CFG_PAUSE = 16;
	localparam int CYCLE_LIMIT = 3000000;
	localparam logic [2:0] OP_BAD_LO = 3'd5;

	typedef struct {
		bit                 is_cfg;
		logic               reg_idx;
		logic [CNT_W-1:0]   reg_val;
		logic [OP_W-1:0]    opc;
		logic [IDX_W-1:0]   idx;
		logic signed [23:0] px, py, pz;
		logic signed [15:0] nx, ny, nz;
		bit                 calm;
	} request_t;

	typedef struct {
		logic [FIDX_W-1:0] face;
		logic [DIST_W-1:0] dist_v;
		logic              vres;
	} wall_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [OP_W-1:0] op = '0;
	logic [IDX_W-1:0] index = '0;
	logic signed [23:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [15:0] norm_x = '0, norm_y = '0, norm_z = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [CNT_W-1:0] cfg_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [FIDX_W-1:0] face_index;
	logic [DIST_W-1:0] distance;
	logic valid_res;

	wall_distance_nearest_face uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .index(index),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.face_index(face_index), .distance(distance), .valid_res(valid_res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic signed [23:0] cen_x [FACES], cen_y [FACES], cen_z [FACES];
	logic signed [15:0] nrm_x [FACES], nrm_y [FACES], nrm_z [FACES];
	logic [DIST_W-1:0] min_dist [STATES];
	logic [FIDX_W-1:0] last_face;
	logic [CNT_W-1:0] face_count;
	logic use_z;

	request_t pending_q[$];
	wall_result_t expected_q[$];
	bit loaded [FACES];
	int errors = 0;
	int cycles = 0;
	bit calm_mode = 0;

	function automatic logic [DIST_W-1:0] normal_distance(int f, longint x, longint y,
			longint z);
		longint dx, dy, dz, p;
		dx = x - longint'(cen_x[f]);
		dy = y - longint'(cen_y[f]);
		dz = use_z ? z - longint'(cen_z[f]) : 0;
		p = dx * longint'(nrm_x[f]) + dy * longint'(nrm_y[f]) + dz * longint'(nrm_z[f]);
		if (p < 0)
			p = -p;
		p = p >>> 14;
		return (p > longint'(DIST_MAX)) ? DIST_MAX : p[DIST_W-1:0];
	endfunction

	task automatic predict_request(request_t r);
		wall_result_t e;
		int n, best;
		longint unsigned d, bestd, dx, dy, dz;
		logic [DIST_W-1:0] v;
		e = '{face: '0, dist_v: '0, vres: 1'b0};
		n = (face_count > FACES) ? FACES : face_count;
		case (r.opc)
			OP_LOAD: begin
				if (r.idx < FACES) begin
					cen_x[r.idx] = r.px; cen_y[r.idx] = r.py; cen_z[r.idx] = r.pz;
					nrm_x[r.idx] = r.nx; nrm_y[r.idx] = r.ny; nrm_z[r.idx] = r.nz;
				end
			end
			OP_QUERY: begin
				best = 0;
				bestd = 0;
				for (int i = 0; i < n; i++) begin
					dx = longint'(r.px) - longint'(cen_x[i]);
					dy = longint'(r.py) - longint'(cen_y[i]);
					dz = use_z ? longint'(r.pz) - longint'(cen_z[i]) : 0;
					d = dx * dx + dy * dy + dz * dz;
					if (i == 0 || d < bestd) begin
						bestd = d;
						best = i;
					end
				end
				if (n > 0)
					e.dist_v = normal_distance(best, r.px, r.py, r.pz);
				last_face = FIDX_W'(best);
				e.face = last_face;
				e.vres = 1'b1;
			end
			OP_STATE: begin
				if (r.idx < STATES) begin
					if (n == 0) begin
						v = '0;
					end else begin
						v = normal_distance(last_face, r.px, r.py, r.pz);
						if (min_dist[r.idx] < v)
							v = min_dist[r.idx];
						e.face = last_face;
					end
					min_dist[r.idx] = v;
					e.dist_v = v;
					e.vres = 1'b1;
				end
			end
			OP_WALL: begin
				if (r.idx < STATES)
					min_dist[r.idx] = '0;
			end
			OP_CLEAR: begin
				foreach (min_dist[i])
					min_dist[i] = DIST_MAX;
			end
			default: ;
		endcase
		expected_q.insert(expected_q.size(), e);
	endtask

	task automatic report(string what, longint want, longint got);
		$display("mismatch %s: expected %0d got %0d", what, want, got);
		errors++;
	endtask

	// driver for the request and register channels
	request_t cur;
	bit in_busy, cfg_busy;
	int gap = 0;
	int quiet = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
			gap = 0;
			quiet = 0;
		end else begin
			in_busy = in_valid;
			cfg_busy = cfg_valid;
			if (in_valid && in_ready) begin
				predict_request(cur);
				in_busy = 0;
				if (!calm_mode && $urandom_range(0, 3) == 0)
					gap = $urandom_range(1, 14);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_FACE_COUNT)
					face_count = cfg_data;
				else
					use_z = cfg_data[0];
				cfg_busy = 0;
			end
			if (expected_q.size() == 0 && !in_busy && !cfg_busy)
				quiet++;
			else
				quiet = 0;
			if (!in_busy && !cfg_busy && pending_q.size() > 0) begin
				if (pending_q[0].is_cfg) begin
					if (quiet >= CFG_PAUSE) begin
						cur = pending_q.pop_front();
						cfg_busy = 1;
						cfg_index <= cur.reg_idx;
						cfg_data <= cur.reg_val;
					end
				end else if (gap > 0) begin
					gap--;
				end else begin
					cur = pending_q.pop_front();
					calm_mode = cur.calm;
					in_busy = 1;
					op <= cur.opc;
					index <= cur.idx;
					pos_x <= cur.px; pos_y <= cur.py; pos_z <= cur.pz;
					norm_x <= cur.nx; norm_y <= cur.ny; norm_z <= cur.nz;
				end
			end
			in_valid <= in_busy;
			cfg_valid <= cfg_busy;
		end
	end

	// result monitor with random back pressure
	int stall = 0;
	wall_result_t e_head;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected result face", -1, face_index);
				end else begin
					e_head = expected_q.pop_front();
					if (valid_res !== e_head.vres)
						report("valid_res", e_head.vres, valid_res);
					if (face_index !== e_head.face)
						report("face_index", e_head.face, face_index);
					if (distance !== e_head.dist_v)
						report("distance", e_head.dist_v, distance);
				end
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (!calm_mode && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 14);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// stimulus generation
	bit calm_tail = 0;

	task automatic push_req(logic [OP_W-1:0] o, logic [IDX_W-1:0] i,
			logic signed [23:0] x, logic signed [23:0] y, logic signed [23:0] z,
			logic signed [15:0] a, logic signed [15:0] b, logic signed [15:0] c);
		request_t r;
		r = '{is_cfg: 0, reg_idx: 1'b0, reg_val: '0, opc: o, idx: i, px: x, py: y, pz: z,
			nx: a, ny: b, nz: c, calm: calm_tail};
		if (o == OP_LOAD && i < FACES)
			loaded[i] = 1;
		pending_q.insert(pending_q.size(), r);
	endtask

	task automatic push_cfg(logic ri, logic [CNT_W-1:0] v);
		request_t r;
		r = '{is_cfg: 1, reg_idx: ri, reg_val: v, opc: '0, idx: '0, px: '0, py: '0,
			pz: '0, nx: '0, ny: '0, nz: '0, calm: calm_tail};
		pending_q.insert(pending_q.size(), r);
	endtask

	function automatic logic signed [23:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return 24'($urandom);
			1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
			default: return 24'(($urandom_range(0, 8) - 4) * 4096 + $urandom_range(0, 63) - 32);
		endcase
	endfunction

	function automatic logic signed [15:0] rnd_norm();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return 16'sd16384;
			2: return -16'sd16384;
			3: return 16'sd0;
			default: return 16'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	task automatic push_load(logic [IDX_W-1:0] i);
		push_req(OP_LOAD, i, rnd_coord(), rnd_coord(), rnd_coord(),
			rnd_norm(), rnd_norm(), rnd_norm());
	endtask

	// every scanned slot must hold a face before the count goes live
	task automatic set_count(int c);
		for (int i = 0; i < ((c > FACES) ? FACES : c); i++)
			if (!loaded[i])
				push_load(IDX_W'(i));
		push_cfg(CFG_FACE_COUNT, CNT_W'(c));
	endtask

	task automatic random_phase(int items);
		int k;
		for (int j = 0; j < items; j++) begin
			k = $urandom_range(0, 99);
			if (k < 18)
				push_load(IDX_W'($urandom_range(0, 9) == 0 ? $urandom_range(0, 4095)
					: $urandom_range(0, 47)));
			else if (k < 55)
				push_req(OP_QUERY, IDX_W'($urandom), rnd_coord(), rnd_coord(), rnd_coord(),
					16'($urandom), 16'($urandom), 16'($urandom));
			else if (k < 88)
				push_req(OP_STATE, IDX_W'($urandom_range(0, 9) == 0 ? $urandom_range(0, 4095)
					: $urandom_range(0, 7)), rnd_coord(), rnd_coord(), rnd_coord(),
					16'($urandom), 16'($urandom), 16'($urandom));
			else if (k < 94)
				push_req(OP_WALL, IDX_W'($urandom_range(0, 7)), 24'($urandom),
					24'($urandom), 24'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom));
			else if (k < 96)
				push_req(OP_CLEAR, IDX_W'($urandom), 24'($urandom), 24'($urandom),
					24'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			else
				push_req(3'($urandom_range(OP_BAD_LO, 7)), IDX_W'($urandom),
					24'($urandom), 24'($urandom), 24'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		foreach (min_dist[i])
			min_dist[i] = DIST_MAX;
		foreach (cen_x[i]) begin
			cen_x[i] = '0; cen_y[i] = '0; cen_z[i] = '0;
			nrm_x[i] = '0; nrm_y[i] = '0; nrm_z[i] = '0;
			loaded[i] = 0;
		end
		last_face = '0;
		face_count = '0;
		use_z = 1'b1;

		// no wall yet
		push_req(OP_STATE, 12'd0, 24'sd4096, 24'sd0, 24'sd0, '0, '0, '0);
		push_req(OP_QUERY, 12'd4095, 24'sh7FFFFF, 24'sh800000, 24'sd1, '0, '0, '0);
		push_req(OP_BAD_LO, 12'd1, '0, '0, '0, '0, '0, '0);
		push_req(3'd6, 12'd2, '0, '0, '0, '0, '0, '0);
		push_req(3'd7, 12'd3, '1, '1, '1, '1, '1, '1);
		push_req(OP_WALL, 12'd4095, '0, '0, '0, '0, '0, '0);
		push_req(OP_CLEAR, '0, '0, '0, '0, '0, '0, '0);
		// tie between faces 0 and 2, face 1 at the far corner
		push_req(OP_LOAD, 12'd0, '0, '0, '0, 16'sd16384, '0, '0);
		push_req(OP_LOAD, 12'd1, 24'sh800000, 24'sh800000, 24'sh800000,
			16'sh8000, 16'sh8000, 16'sh8000);
		push_req(OP_LOAD, 12'd2, '0, '0, '0, '0, 16'sd16384, '0);
		push_req(OP_LOAD, 12'd4095, 24'sd5, 24'sd5, 24'sd5, 16'sh7FFF, 16'sh7FFF, '0);
		set_count(3);
		push_req(OP_QUERY, '0, 24'sd4096, 24'sd8192, '0, '0, '0, '0);
		push_req(OP_STATE, 12'd5, -24'sd12288, '0, 24'sd77, '0, '0, '0);
		push_req(OP_STATE, 12'd5, 24'sd409600, '0, '0, '0, '0, '0);
		push_req(OP_WALL, 12'd5, '0, '0, '0, '0, '0, '0);
		push_req(OP_STATE, 12'd5, 24'sd4096, '0, '0, '0, '0, '0);
		push_req(OP_QUERY, '0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, '0, '0, '0);
		push_req(OP_STATE, 12'd4095, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, '0, '0, '0);
		push_cfg(CFG_THREE_D, 11'h7FE);
		push_req(OP_QUERY, '0, 24'sd100, 24'sd3, 24'sh7FFFFF, '0, '0, '0);
		push_req(OP_STATE, 12'd4095, 24'sd100, 24'sd3, 24'sh7FFFFF, '0, '0, '0);
		push_cfg(CFG_THREE_D, 11'h001);

		for (int ph = 0; ph < 6; ph++) begin
			set_count(ph == 0 ? 1 : $urandom_range(0, 7) == 0 ? 0 : $urandom_range(2, 40));
			push_cfg(CFG_THREE_D, CNT_W'($urandom));
			random_phase(60);
		end
		calm_tail = 1;
		set_count(5);
		random_phase(30);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(posedge clk);
		while (pending_q.size() > 0 || in_valid || cfg_valid || expected_q.size() > 0);
		repeat (64) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wdf_pkg.sv
rtl/wdf_front.sv
rtl/wdf_back.sv
rtl/wall_distance_nearest_face.sv
sim/tb.sv
